// ===== sv/u8dls_pkg.sv =====
// shared types and constants for the utf-8 line-split decoder
`timescale 1ns / 1ps

package u8dls_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned KindW = 2;
  localparam int unsigned MaxRes = 5;   // four code points and the end marker
  localparam int unsigned ResCntW = 3;

  localparam logic [ByteW-1:0] SubstChar = 8'h3F;  // '?'
  localparam logic [CpW-1:0]   CrCode    = 21'h0D;
  localparam logic [CpW-1:0]   LfCode    = 21'h0A;

  typedef enum logic [KindW-1:0] {
    KIND_CODE = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e          kind;
    logic [CpW-1:0] cp;
  } res_t;

endpackage

// ===== sv/utf8_decode_line_split.sv =====
// utf-8 decoder with line splitting, one text byte per word
`timescale 1ns / 1ps

// Takes one text byte per cycle on the slave side (tlast marks the final byte of
// the text) and yields decoded items on the master side: a code point, a line
// break for a decoded LF, or an end marker after the final byte. Decoding is
// lenient: the lead byte alone sets the sequence length of 1 to 4 bytes, the
// following bytes are taken whatever their top bits, and a byte that fits no
// lead pattern decodes as '?'. A decoded CR is dropped. If the text ends while
// a sequence is short of bytes, the lead byte gives '?' and the remaining bytes
// are decoded again one after the other. Each accepted byte is decoded in the
// same cycle and its results (none, one, or up to five for the final byte) are
// loaded into a five-entry output shift register; one result leaves per cycle
// while m_axis_tready is high. Throughput is one byte per cycle while each byte
// gives at most one result and the master side takes every result, and a new
// byte is taken in the same cycle that the previous last result is taken, so a
// final byte holds the input off until all but its last result are taken.
module utf8_decode_line_split
  import u8dls_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic              s_axis_tlast,   // end_of_text
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [KindW-1:0]  m_axis_tuser,   // [1:0] item_kind
  output logic              m_axis_tlast    // last_result
);

  // sequence length from a lead byte, zero when no pattern fits
  function automatic logic [2:0] seq_len(input logic [ByteW-1:0] b);
    logic [2:0] l;
    if (b[7] == 1'b0) l = 3'd1;
    else if ((b & 8'hE0) == 8'hC0) l = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) l = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) l = 3'd4;
    else l = 3'd0;
    return l;
  endfunction

  // build a code point from the bytes of one sequence
  function automatic logic [CpW-1:0] assemble(input logic [3:0][ByteW-1:0] p,
                                              input logic [2:0] len);
    logic [CpW-1:0] cp;
    unique case (len)
      3'd2: cp = CpW'({p[0][4:0], p[1][5:0]});
      3'd3: cp = CpW'({p[0][3:0], p[1][5:0], p[2][5:0]});
      3'd4: cp = {p[0][2:0], p[1][5:0], p[2][5:0], p[3][5:0]};
      default: cp = CpW'(p[0]);
    endcase
    return cp;
  endfunction

  function automatic res_t code_res(input logic [CpW-1:0] cp);
    res_t r;
    if (cp == LfCode) begin
      r.kind = KIND_LINE;
      r.cp   = '0;
    end else begin
      r.kind = KIND_CODE;
      r.cp   = cp;
    end
    return r;
  endfunction

  // decoder state
  logic [ByteW-1:0] hb_q [3];
  logic [1:0]       hc_q, hc_d;
  logic [1:0]       need_q, need_d;

  // result shift register, entry 0 drives the master side
  res_t               res_q [MaxRes];
  logic [ResCntW-1:0] cnt_q;

  logic in_acc, out_take;
  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && m_axis_tready);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // decode of the accepted byte
  res_t               lst [MaxRes];
  logic [ResCntW-1:0] n;

  always_comb begin
    logic [3:0][ByteW-1:0] buf_b;
    logic [3:0][ByteW-1:0] win;
    logic [2:0]            len;
    logic [2:0]            pos;
    logic [2:0]            idx;
    logic [2:0]            l;
    logic [CpW-1:0]        cp;
    logic                  emit;

    for (int k = 0; k < MaxRes; k++) lst[k] = '{kind: KIND_END, cp: '0};
    n      = '0;
    hc_d   = hc_q;
    need_d = need_q;
    cp     = '0;
    emit   = 1'b0;
    idx    = '0;
    l      = '0;

    // held bytes followed by the new byte
    for (int k = 0; k < 4; k++) begin
      if (k < 3 && 2'(k) < hc_q) buf_b[k] = hb_q[k < 3 ? k : 0];
      else if (3'(k) == {1'b0, hc_q}) buf_b[k] = s_axis_tdata;
      else buf_b[k] = '0;
    end
    len = {1'b0, hc_q} + 3'd1;
    pos = '0;
    win = '0;

    if (s_axis_tlast) begin
      // the bytes held and the final byte are decoded as a whole text
      for (int s = 0; s < 4; s++) begin
        if (pos < len) begin
          for (int k = 0; k < 4; k++) begin
            idx    = pos + 3'(k);
            win[k] = (idx < 3'd4) ? buf_b[idx[1:0]] : '0;
          end
          l = seq_len(win[0]);
          if (l == 3'd1) begin
            cp  = CpW'(win[0]);
            pos = pos + 3'd1;
          end else if (l >= 3'd2 && (pos + l) <= len) begin
            cp  = assemble(win, l);
            pos = pos + l;
          end else begin
            cp  = CpW'(SubstChar);
            pos = pos + 3'd1;
          end
          if (cp != CrCode) begin
            lst[n] = code_res(cp);
            n      = n + 3'd1;
          end
        end
      end
      lst[n] = '{kind: KIND_END, cp: '0};
      n      = n + 3'd1;
      hc_d   = '0;
      need_d = '0;
    end else if (hc_q == '0 || need_q == '0) begin
      l      = seq_len(s_axis_tdata);
      hc_d   = '0;
      need_d = '0;
      if (l == 3'd1) begin
        cp   = CpW'(s_axis_tdata);
        emit = 1'b1;
      end else if (l == 3'd0) begin
        cp   = CpW'(SubstChar);
        emit = 1'b1;
      end else begin
        hc_d   = 2'd1;
        need_d = 2'(l - 3'd1);
      end
    end else if (need_q == 2'd1) begin
      cp     = assemble(buf_b, len);
      emit   = 1'b1;
      hc_d   = '0;
      need_d = '0;
    end else if (hc_q < 2'd3) begin
      hc_d   = hc_q + 2'd1;
      need_d = need_q - 2'd1;
    end else begin
      hc_d   = '0;
      need_d = '0;
    end

    if (emit && cp != CrCode) begin
      lst[0] = code_res(cp);
      n      = 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q   <= '0;
      need_q <= '0;
    end else if (in_acc) begin
      hc_q   <= hc_d;
      need_q <= need_d;
    end
  end

  // held bytes take every non-final byte but the one that completes a sequence
  always_ff @(posedge clk_i) begin
    if (in_acc && !s_axis_tlast) begin
      if (hc_q == '0 || need_q == '0) hb_q[0] <= s_axis_tdata;
      else if (need_q >= 2'd2 && hc_q < 2'd3) hb_q[hc_q] <= s_axis_tdata;
    end
  end

  // result list: load on accept, otherwise shift out one per taken word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= n;
    end else if (out_take) begin
      cnt_q <= cnt_q - ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < MaxRes; k++) res_q[k] <= lst[k];
    end else if (out_take) begin
      for (int k = 0; k < MaxRes - 1; k++) res_q[k] <= res_q[k+1];
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {3'b000, res_q[0].cp};
  assign m_axis_tuser  = res_q[0].kind;
  assign m_axis_tlast  = (cnt_q == ResCntW'(1));

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(MaxRes))
    else $error("result count out of range");

  a_ready_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> cnt_q <= ResCntW'(1))
    else $error("input taken while results still queued");

  a_end_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (m_axis_tvalid && hc_q == '0 && need_q == '0))
    else $error("final byte gave no results or left state behind");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_END) |-> m_axis_tlast)
    else $error("end marker not the last result");

  a_state_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hc_q == '0) == (need_q == '0))
    else $error("held count and missing bytes disagree");
`endif

endmodule
